>>> hw/rtl/assert_macros.svh
// assertion macros for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> hw/rtl/sha256_pkg.sv
// package with sha-256 constants and round functions
`timescale 1ns / 1ps
package sha256_pkg;
   localparam int WordWidth = 32;
   localparam int BufDepth  = 16;
   localparam int HashDepth = 8;

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66b,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

   localparam logic [31:0] InitHash [8] = '{
      32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
      32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] LenPos  = 6'd56;

   typedef logic [31:0] word_type;

   function automatic word_type ror(input word_type v, input int n);
      ror = (v >> n) | (v << (32 - n));
   endfunction

   function automatic word_type sig0(input word_type x);
      sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
   endfunction
   function automatic word_type sig1(input word_type x);
      sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
   endfunction
   function automatic word_type bsig0(input word_type x);
      bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
   endfunction
   function automatic word_type bsig1(input word_type x);
      bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
   endfunction
endpackage

>>> hw/rtl/sha256_ram.sv
// generic single-port-write dual-read ram with registered read
`timescale 1ns / 1ps
module sha256_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr_a,
   output logic [Width-1:0]         rd_data_a,
   input  logic [$clog2(Depth)-1:0] rd_addr_b,
   output logic [Width-1:0]         rd_data_b
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule

>>> hw/rtl/sha256_stream_hasher.sv
// top level: byte stream in, sha-256 digest words out
//
// req channel: one beat per message byte; tuser[0] marks a beat that carries
// a byte, tlast closes the message. a beat with neither does nothing.
// rsp channel: eight beats per message, word 0 first, tlast on word 7.
// a byte beat is taken in the idle state and merged into the 16-word block ram
// (read, then write) before the next beat is taken. the 64th byte of a block
// starts a compression: a load step, 64 rounds (three ram read phases, a phase
// that forms and stores the schedule word, an update) and a fold step.
// closing a message writes 0x80, zero bytes and the eight length bytes, each
// read and then written, and compresses one or two final blocks; the digest
// words then leave one per cycle while rsp_tready is high.
// req_tready is low while a byte is merged, while a block compresses, while
// padding runs and while digest words wait; a stalled rsp side holds the
// current word.
// reset clears the controller, the hash registers to the initial values and
// the length count; the ram needs no clearing.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // has_byte
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word[31:0], word_index[34:32], zero fill
   output logic        rsp_tlast    // last_word
);
   import sha256_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_BYTE, S_PAD, S_LEN, S_RUN_INIT, S_RD0, S_RD1, S_RD2, S_RD3,
      S_ROUND, S_FOLD, S_OUT
   } state_type;

   state_type   state_ff;
   logic [5:0]  pos_ff;
   logic [63:0] bits_ff;
   logic [63:0] len_ff;
   logic        ending_ff;
   logic [7:0]  byte_ff;
   logic [5:0]  rnd_ff;
   logic [2:0]  oidx_ff;
   word_type    h_ff [8];
   word_type    v_ff [8];
   word_type    w0_ff, w15_ff, w7_ff;
   // the byte write for a position happens in the cycle after its read is issued
   logic        rdy_ff;
   logic        len_done_ff;

   logic        wr_en;
   logic [3:0]  wr_addr, ra, rb;
   word_type    wr_data, rd_a, rd_b, w_new, t1, t2;

   sha256_ram #(.Width(WordWidth), .Depth(BufDepth)) u_buf (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr_a(ra), .rd_data_a(rd_a), .rd_addr_b(rb), .rd_data_b(rd_b));

   assign w_new = (rnd_ff < 6'd16) ? w0_ff : (w0_ff + sig0(w15_ff) + w7_ff + sig1(rd_b));
   assign t1 = v_ff[7] + bsig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + RoundK[rnd_ff] + w0_ff;
   assign t2 = bsig0(v_ff[0]) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^
               (v_ff[1] & v_ff[2]));

   // read addresses per phase: rd0 word j and j-15, rd1 j-7, rd2 j-2; rd3 forms w[j]
   always_comb begin
      ra = rnd_ff[3:0];
      rb = rnd_ff[3:0] - 4'd15;
      unique case (state_ff)
         S_RD1:   rb = rnd_ff[3:0] - 4'd7;
         S_RD2:   rb = rnd_ff[3:0] - 4'd2;
         S_BYTE, S_PAD, S_LEN: ra = pos_ff[5:2];
         default: ;
      endcase
   end

   // byte states shift the byte into the read-back word; rd3 stores w[j] for j >= 16
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff[5:2];
      wr_data = (pos_ff[1:0] == 2'd0) ? {24'd0, byte_ff} : {rd_a[23:0], byte_ff};
      if (state_ff == S_RD3) begin
         wr_en   = (rnd_ff >= 6'd16);
         wr_addr = rnd_ff[3:0];
         wr_data = w_new;
      end else if (state_ff == S_BYTE || state_ff == S_PAD || state_ff == S_LEN) begin
         wr_en = rdy_ff;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {5'd0, oidx_ff, h_ff[oidx_ff]};
   assign rsp_tlast  = (oidx_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pos_ff    <= '0;
         bits_ff   <= '0;
         ending_ff <= 1'b0;
         rnd_ff    <= '0;
         oidx_ff   <= '0;
         rdy_ff    <= 1'b0;
         for (int i = 0; i < 8; i++) h_ff[i] <= InitHash[i];
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               rdy_ff <= 1'b0;
               if (req_tvalid) begin
                  byte_ff   <= req_tdata;
                  ending_ff <= req_tlast;
                  len_ff    <= bits_ff + (req_tuser ? 64'd8 : 64'd0);
                  if (req_tuser) begin
                     bits_ff  <= bits_ff + 64'd8;
                     state_ff <= S_BYTE;
                  end else if (req_tlast) begin
                     byte_ff  <= PadByte;
                     state_ff <= S_PAD;
                  end
               end
            end
            S_BYTE, S_PAD, S_LEN: begin
               // rdy_ff low issues the read, rdy_ff high writes the merged word
               if (!rdy_ff) begin
                  rdy_ff <= 1'b1;
               end else begin
                  rdy_ff <= 1'b0;
                  pos_ff <= pos_ff + 6'd1;
                  if (pos_ff == 6'd63) begin
                     rnd_ff   <= '0;
                     byte_ff  <= (state_ff == S_BYTE) ? PadByte : 8'd0;
                     state_ff <= S_RUN_INIT;
                  end else if (state_ff == S_BYTE) begin
                     if (ending_ff) begin
                        byte_ff  <= PadByte;
                        state_ff <= S_PAD;
                     end else begin
                        state_ff <= S_IDLE;
                     end
                  end else if (state_ff == S_PAD) begin
                     if (pos_ff + 6'd1 == LenPos) begin
                        byte_ff  <= len_ff[63:56];
                        state_ff <= S_LEN;
                     end else begin
                        byte_ff <= 8'd0;
                     end
                  end else begin
                     len_ff  <= {len_ff[55:0], 8'd0};
                     byte_ff <= len_ff[55:48];
                  end
               end
            end
            S_RUN_INIT: begin
               for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
               state_ff <= S_RD0;
            end
            S_RD0: state_ff <= S_RD1;
            S_RD1: begin
               w0_ff <= rd_a; w15_ff <= rd_b; state_ff <= S_RD2;
            end
            S_RD2: begin
               w7_ff <= rd_b; state_ff <= S_RD3;
            end
            S_RD3: begin
               w0_ff <= w_new; state_ff <= S_ROUND;
            end
            S_ROUND: begin
               v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1; v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1];
               v_ff[1] <= v_ff[0]; v_ff[0] <= t1 + t2;
               rnd_ff <= rnd_ff + 6'd1;
               state_ff <= (rnd_ff == 6'd63) ? S_FOLD : S_RD0;
            end
            S_FOLD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               if (len_done_ff) state_ff <= S_OUT;
               else if (!ending_ff) state_ff <= S_IDLE;
               else state_ff <= S_PAD;
               oidx_ff <= '0;
            end
            S_OUT: begin
               if (rsp_tready) begin
                  oidx_ff <= oidx_ff + 3'd1;
                  if (oidx_ff == 3'd7) begin
                     state_ff  <= S_IDLE;
                     bits_ff   <= '0;
                     ending_ff <= 1'b0;
                     for (int i = 0; i < 8; i++) h_ff[i] <= InitHash[i];
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // track whether the length block has been emitted
   always_ff @(posedge clock) begin
      if (reset) len_done_ff <= 1'b0;
      else if (state_ff == S_LEN && rdy_ff && pos_ff == 6'd63) len_done_ff <= 1'b1;
      else if (state_ff == S_OUT) len_done_ff <= 1'b0;
   end

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_CLK(a_one_side, clock, reset, !(req_tready && rsp_tvalid))
   `ASSERT_CLK(a_last_idx, clock, reset, rsp_tvalid |-> (rsp_tlast == (rsp_tdata[34:32] == 3'd7)))
   `ASSERT_CLK(a_zero_fill, clock, reset, rsp_tvalid |-> rsp_tdata[39:35] == 5'd0)
   `ASSERT_CLK(a_out_pos, clock, reset, state_ff == S_OUT |-> pos_ff == 6'd0)
endmodule
